// ===== sv/rgbpm_pkg.sv =====
// Shared types, constants and helper functions for the RGB to pixel mapper.
`default_nettype none

package rgbpm_pkg;

    // Field and datapath widths
    localparam int CH_W          = 8;
    localparam int WIDE_W        = 16;
    localparam int PIX_W         = 32;
    localparam int SQ_W          = 2 * WIDE_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int PE_W          = 9;
    localparam int MODE_W        = 2;
    localparam int CFG_DATA_W    = PE_W;
    localparam int PAL_W         = 3 * WIDE_W;

    // Table memory: four banks of 256 words, cube in the last bank
    localparam int CHANNEL_LEVELS = 256;
    localparam int TSEL_W         = 2;
    localparam int TBL_AW         = TSEL_W + CH_W;
    localparam int TBL_DEPTH      = 4 * CHANNEL_LEVELS;
    localparam int CUBE_SIZE      = 225;

    // Cube quantization
    localparam int CUBE_RB_STEP   = 52;
    localparam int CUBE_G_STEP    = 31;
    localparam int CUBE_G_LEVELS  = 9;
    localparam int CUBE_B_LEVELS  = 5;
    localparam int CUBE_RB_MAXQ   = 4;
    localparam int CUBE_G_MAXQ    = 8;

    // Palette channels are the input channel shifted up by this much
    localparam int WIDEN_SHIFT    = 8;

    localparam int PALETTE_DEPTH_DEFAULT = 256;
    localparam logic [PE_W-1:0] PALETTE_ENTRIES_RESET = 9'd256;

    typedef enum logic [2:0] {
        CMD_LOAD_PAL   = 3'd0,
        CMD_LOAD_RED   = 3'd1,
        CMD_LOAD_GREEN = 3'd2,
        CMD_LOAD_BLUE  = 3'd3,
        CMD_LOAD_CUBE  = 3'd4,
        CMD_CONVERT    = 3'd5
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_DIRECT  = 2'd0,
        MODE_NEAREST = 2'd1,
        MODE_CUBE    = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic {
        REG_MAP_MODE        = 1'b0,
        REG_PALETTE_ENTRIES = 1'b1
    } reg_idx_t;

    typedef enum logic [TSEL_W-1:0] {
        TSEL_RED   = 2'd0,
        TSEL_GREEN = 2'd1,
        TSEL_BLUE  = 2'd2,
        TSEL_CUBE  = 2'd3
    } tsel_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_LOOKUP = 2'd2,
        ST_DRAIN  = 2'd3
    } state_t;

    // Quotient by 52 of an 8-bit channel (0..4)
    function automatic logic [2:0] div_rb(input logic [CH_W-1:0] v);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= CUBE_RB_MAXQ; k++) begin
            if (v >= CH_W'(k * CUBE_RB_STEP)) q = 3'(k);
        end
        return q;
    endfunction

    // Quotient by 31 of an 8-bit channel (0..8)
    function automatic logic [3:0] div_g(input logic [CH_W-1:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k <= CUBE_G_MAXQ; k++) begin
            if (v >= CH_W'(k * CUBE_G_STEP)) q = 4'(k);
        end
        return q;
    endfunction

    // Cube entry for a colour; never above 224
    function automatic logic [CH_W-1:0] cube_index(input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] b);
        logic [CH_W-1:0] qr;
        logic [CH_W-1:0] qg;
        logic [CH_W-1:0] qb;
        qr = CH_W'(div_rb(r));
        qg = CH_W'(div_g(g));
        qb = CH_W'(div_rb(b));
        return CH_W'(qr * CH_W'(CUBE_G_LEVELS * CUBE_B_LEVELS)
                     + qg * CH_W'(CUBE_B_LEVELS) + qb);
    endfunction

    // Square of the absolute difference of two 16-bit channels
    function automatic logic [SQ_W-1:0] sq_diff(input logic [WIDE_W-1:0] a,
                                                input logic [WIDE_W-1:0] b);
        logic [WIDE_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

`default_nettype wire

// ===== sv/rgb_to_pixel_mapper.sv =====
// RGB to pixel mapper top level: table lookup, colour cube and nearest palette search.
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  ----------------------------
//  item in   command, entry_*, in_red/green/blue       start high while busy low
//  result    pixel_value                               done strobe, one cycle
//  config    cfg_write, cfg_index, cfg_data            cfg_write, taken at once
//
//  Loads are written when taken and give no result. A convert in mode 3 gives its
//  result in the cycle after it is taken; direct mode makes three reads of the single
//  table memory port and cube mode one. Nearest mode reads the n searched entries
//  through the one read port of the palette memory (one entry per cycle), then a
//  square stage and a compare stage. Reset clears control state only; memory contents
//  are undefined until loaded. The receiver cannot stall: done lasts one cycle.
`default_nettype none

module rgb_to_pixel_mapper
    import rgbpm_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [2:0]            command,
    input  wire logic [CH_W-1:0]       entry_index,
    input  wire logic [WIDE_W-1:0]     entry_red,
    input  wire logic [WIDE_W-1:0]     entry_green,
    input  wire logic [WIDE_W-1:0]     entry_blue,
    input  wire logic [PIX_W-1:0]      entry_pixel,
    input  wire logic [CH_W-1:0]       in_red,
    input  wire logic [CH_W-1:0]       in_green,
    input  wire logic [CH_W-1:0]       in_blue,
    output logic                       done,
    output logic [PIX_W-1:0]           pixel_value,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    // Configuration registers
    logic [MODE_W-1:0] map_mode_reg;
    logic [PE_W-1:0]   pal_entries_reg;

    // Control
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_convert;
    logic   issue_pal;
    logic   issue_tbl;
    logic   tbl_last_issue;

    // Latched colour
    logic [CH_W-1:0] col_r_reg;
    logic [CH_W-1:0] col_g_reg;
    logic [CH_W-1:0] col_b_reg;

    // Palette memory and scan pipeline
    logic [PAL_W-1:0]  pal_mem [PALETTE_DEPTH];
    logic [PAL_W-1:0]  pal_rdata_reg;
    logic [PAL_AW-1:0] ptr_reg;
    logic [PAL_AW-1:0] scan_start;
    logic [PE_W-1:0]   pe_m1;
    logic              pe_over;
    logic              first_reg;
    logic              pal_load;

    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic              rd_first_reg;
    logic [PAL_AW-1:0] rd_idx_reg;

    logic              sq_valid_reg;
    logic              sq_last_reg;
    logic              sq_first_reg;
    logic [PAL_AW-1:0] sq_idx_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [SQ_W-1:0]   sq_g_reg;
    logic [SQ_W-1:0]   sq_b_reg;

    logic [DIST_W-1:0] sum_dist;
    logic              take;
    logic [DIST_W-1:0] best_dist_reg;
    logic [PAL_AW-1:0] best_idx_reg;

    // Table memory and lookup pipeline
    logic [PIX_W-1:0]  tbl_mem [TBL_DEPTH];
    logic [PIX_W-1:0]  tbl_rdata_reg;
    logic [TBL_AW-1:0] tbl_raddr;
    logic [TBL_AW-1:0] tbl_waddr;
    logic              tbl_load;
    logic [1:0]        phase_reg;
    logic              tr_valid_reg;
    logic              tr_last_reg;
    logic [PIX_W-1:0]  acc_reg;

    // Result
    logic             done_reg;
    logic             done_next;
    logic [PIX_W-1:0] pixel_reg;
    logic [PIX_W-1:0] pixel_next;

    assign accept     = start && !busy;
    assign is_convert = (command == CMD_CONVERT);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg    <= MODE_DIRECT;
            pal_entries_reg <= PALETTE_ENTRIES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAP_MODE:        map_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_PALETTE_ENTRIES: pal_entries_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Clamp the entry count: zero searches entry 0, too many saturates
    assign pe_m1   = pal_entries_reg - 9'd1;
    assign pe_over = 32'(pal_entries_reg) > 32'(PALETTE_DEPTH);
    always_comb
    begin
        if (pal_entries_reg == '0)
            scan_start = '0;
        else if (pe_over)
            scan_start = PAL_AW'(PALETTE_DEPTH - 1);
        else
            scan_start = PAL_AW'(pe_m1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_convert)
                begin
                    case (map_mode_reg)
                        MODE_NEAREST: state_next = ST_SCAN;
                        MODE_DIRECT:  state_next = ST_LOOKUP;
                        MODE_CUBE:    state_next = ST_LOOKUP;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (ptr_reg == '0) state_next = ST_DRAIN;
            end
            ST_LOOKUP:
            begin
                if (tbl_last_issue) state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if ((sq_valid_reg && sq_last_reg) || (tr_valid_reg && tr_last_reg))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        issue_pal = (state_reg == ST_SCAN);
        issue_tbl = (state_reg == ST_LOOKUP);
    end

    assign tbl_last_issue = (map_mode_reg != MODE_DIRECT) || (phase_reg == 2'd2);

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            first_reg <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ptr_reg   <= scan_start;
                first_reg <= 1'b1;
                phase_reg <= '0;
            end
            else
            begin
                if (issue_pal)
                begin
                    ptr_reg   <= ptr_reg - PAL_AW'(1);
                    first_reg <= 1'b0;
                end
                if (issue_tbl) phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    // Hold the colour of the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_r_reg <= in_red;
            col_g_reg <= in_green;
            col_b_reg <= in_blue;
        end
    end

    // Palette memory: load port and scan read port
    assign pal_load = accept && (command == CMD_LOAD_PAL)
                      && (32'(entry_index) < 32'(PALETTE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (pal_load)
            pal_mem[PAL_AW'(entry_index)] <= {entry_red, entry_green, entry_blue};
        pal_rdata_reg <= pal_mem[ptr_reg];
    end

    // Scan pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            rd_first_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            sq_last_reg  <= 1'b0;
            sq_first_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue_pal;
            rd_last_reg  <= issue_pal && (ptr_reg == '0);
            rd_first_reg <= issue_pal && first_reg;
            sq_valid_reg <= rd_valid_reg;
            sq_last_reg  <= rd_valid_reg && rd_last_reg;
            sq_first_reg <= rd_valid_reg && rd_first_reg;
        end
    end

    // Square the channel differences
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= ptr_reg;
        sq_idx_reg <= rd_idx_reg;
        sq_r_reg   <= sq_diff({col_r_reg, CH_W'(0)}, pal_rdata_reg[PAL_W-1 -: WIDE_W]);
        sq_g_reg   <= sq_diff({col_g_reg, CH_W'(0)}, pal_rdata_reg[2*WIDE_W-1 -: WIDE_W]);
        sq_b_reg   <= sq_diff({col_b_reg, CH_W'(0)}, pal_rdata_reg[WIDE_W-1:0]);
    end

    // Sum and compare; only a strictly smaller distance replaces the best
    assign sum_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign take     = sq_first_reg || (sum_dist < best_dist_reg);

    always_ff @(posedge clk)
    begin
        if (sq_valid_reg && take)
        begin
            best_dist_reg <= sum_dist;
            best_idx_reg  <= sq_idx_reg;
        end
    end

    // Table memory addresses
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                if (map_mode_reg == MODE_CUBE)
                    tbl_raddr = {TSEL_CUBE, cube_index(col_r_reg, col_g_reg, col_b_reg)};
                else
                    tbl_raddr = {TSEL_RED, col_r_reg};
            end
            2'd1:    tbl_raddr = {TSEL_GREEN, col_g_reg};
            default: tbl_raddr = {TSEL_BLUE, col_b_reg};
        endcase
    end

    always_comb
    begin
        tbl_load  = 1'b0;
        tbl_waddr = {TSEL_RED, entry_index};
        if (accept)
        begin
            if (command inside {CMD_LOAD_RED, CMD_LOAD_GREEN, CMD_LOAD_BLUE})
                tbl_load = 1'b1;
            else if (command == CMD_LOAD_CUBE)
                tbl_load = (32'(entry_index) < 32'(CUBE_SIZE));
        end
        case (command)
            CMD_LOAD_GREEN: tbl_waddr = {TSEL_GREEN, entry_index};
            CMD_LOAD_BLUE:  tbl_waddr = {TSEL_BLUE, entry_index};
            CMD_LOAD_CUBE:  tbl_waddr = {TSEL_CUBE, entry_index};
            default:        tbl_waddr = {TSEL_RED, entry_index};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_load)
            tbl_mem[tbl_waddr] <= entry_pixel;
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    // Lookup pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tr_valid_reg <= 1'b0;
            tr_last_reg  <= 1'b0;
        end
        else
        begin
            tr_valid_reg <= issue_tbl;
            tr_last_reg  <= issue_tbl && tbl_last_issue;
        end
    end

    // Accumulate the ORed channel entries
    always_ff @(posedge clk)
    begin
        if (accept)
            acc_reg <= '0;
        else if (tr_valid_reg && !tr_last_reg)
            acc_reg <= acc_reg | tbl_rdata_reg;
    end

    // Result selection
    always_comb
    begin
        done_next  = 1'b0;
        pixel_next = '0;
        if (tr_valid_reg && tr_last_reg)
        begin
            done_next  = 1'b1;
            pixel_next = acc_reg | tbl_rdata_reg;
        end
        else if (sq_valid_reg && sq_last_reg)
        begin
            done_next  = 1'b1;
            pixel_next = take ? PIX_W'(sq_idx_reg) : PIX_W'(best_idx_reg);
        end
        else if (accept && is_convert && (map_mode_reg == MODE_UNUSED))
        begin
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (done_next) pixel_reg <= pixel_next;
    end

    assign done        = done_reg;
    assign pixel_value = pixel_reg;

    // A result only appears once the block is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Unused mode answers in the next cycle
    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_convert && (map_mode_reg == MODE_UNUSED)) |=> done)
        else $error("unused mode convert gave no result");

    // No read is in flight while idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(rd_valid_reg || sq_valid_reg || tr_valid_reg))
        else $error("pipeline busy while idle");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for rgb_to_pixel_mapper: directed and random items checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbpm_pkg::*;

    localparam int PAL_DEPTH          = PALETTE_DEPTH_DEFAULT;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int GAP_MAX            = 14;
    localparam int SETTLE_CYCLES      = 4;
    localparam int DRAIN_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT     = 5000;
    localparam int MAX_REPORTS        = 10;
    localparam int CONVERTS_PER_PHASE = 8;
    localparam int PHASES             = 11;

    typedef struct {
        logic [2:0]        cmd;
        logic [CH_W-1:0]   idx;
        logic [WIDE_W-1:0] ent_r;
        logic [WIDE_W-1:0] ent_g;
        logic [WIDE_W-1:0] ent_b;
        logic [PIX_W-1:0]  pix;
        logic [CH_W-1:0]   r;
        logic [CH_W-1:0]   g;
        logic [CH_W-1:0]   b;
    } map_item_t;

    // Mirror of the mapper's stores and registers, plus the queue of pixels still owed
    class pixel_checker;
        logic [WIDE_W-1:0] pal_red   [PAL_DEPTH];
        logic [WIDE_W-1:0] pal_green [PAL_DEPTH];
        logic [WIDE_W-1:0] pal_blue  [PAL_DEPTH];
        logic [PIX_W-1:0]  red_tbl   [CHANNEL_LEVELS];
        logic [PIX_W-1:0]  green_tbl [CHANNEL_LEVELS];
        logic [PIX_W-1:0]  blue_tbl  [CHANNEL_LEVELS];
        logic [PIX_W-1:0]  cube_tbl  [CUBE_SIZE];
        bit [PAL_DEPTH-1:0]      pal_set;
        bit [CHANNEL_LEVELS-1:0] red_set;
        bit [CHANNEL_LEVELS-1:0] green_set;
        bit [CHANNEL_LEVELS-1:0] blue_set;
        bit [255:0]              cube_set;
        mode_t            mode;
        logic [PE_W-1:0]  entries;
        logic [PIX_W-1:0] pending_pixels [$];
        int errors;
        int checked;
        int loads;
        int spares;
        int converted;
        int converts_by_mode [4];

        function new();
            mode = MODE_DIRECT;
            entries = PALETTE_ENTRIES_RESET;
            pal_set = '0;
            red_set = '0;
            green_set = '0;
            blue_set = '0;
            cube_set = '0;
            errors = 0;
            checked = 0;
            loads = 0;
            spares = 0;
            converted = 0;
            foreach (converts_by_mode[m]) converts_by_mode[m] = 0;
        endfunction

        function void write_reg(input reg_idx_t which, input logic [CFG_DATA_W-1:0] data);
            if (which == REG_MAP_MODE)
                mode = mode_t'(data[MODE_W-1:0]);
            else
                entries = data;
        endfunction

        // Entries searched: zero means one, anything above the depth saturates
        function int search_count();
            int n;
            n = int'(entries);
            if (n == 0) n = 1;
            if (n > PAL_DEPTH) n = PAL_DEPTH;
            return n;
        endfunction

        function logic [63:0] chan_sq(input logic [WIDE_W-1:0] a, input logic [WIDE_W-1:0] b);
            logic [63:0] d;
            d = (a > b) ? 64'(a - b) : 64'(b - a);
            return d * d;
        endfunction

        function logic [63:0] color_dist(input int p, input logic [CH_W-1:0] r,
                                         input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
            return chan_sq({r, 8'h00}, pal_red[p]) + chan_sq({g, 8'h00}, pal_green[p])
                   + chan_sq({b, 8'h00}, pal_blue[p]);
        endfunction

        // Scan from the top down; only a strictly closer entry takes over
        function logic [PIX_W-1:0] nearest_entry(input logic [CH_W-1:0] r,
                                                 input logic [CH_W-1:0] g,
                                                 input logic [CH_W-1:0] b);
            logic [63:0] cand_dist;
            logic [63:0] best_dist;
            int best;
            best = search_count() - 1;
            best_dist = color_dist(best, r, g, b);
            for (int p = best - 1; p >= 0; p--) begin
                cand_dist = color_dist(p, r, g, b);
                if (cand_dist < best_dist) begin
                    best_dist = cand_dist;
                    best = p;
                end
            end
            return PIX_W'(best);
        endfunction

        function logic [PIX_W-1:0] map_color(input map_item_t it);
            int ci;
            case (mode)
                MODE_DIRECT:
                    return red_tbl[it.r] | green_tbl[it.g] | blue_tbl[it.b];
                MODE_NEAREST:
                    return nearest_entry(it.r, it.g, it.b);
                MODE_CUBE: begin
                    ci = ((int'(it.r) / CUBE_RB_STEP) * CUBE_G_LEVELS + int'(it.g) / CUBE_G_STEP)
                         * CUBE_B_LEVELS + int'(it.b) / CUBE_RB_STEP;
                    return cube_tbl[ci];
                end
                default:
                    return '0;
            endcase
        endfunction

        // Apply an accepted item to the mirror; a convert owes one pixel
        function void note_item(input map_item_t it);
            case (it.cmd)
                CMD_LOAD_PAL: begin
                    loads++;
                    if (int'(it.idx) < PAL_DEPTH) begin
                        pal_red[it.idx] = it.ent_r;
                        pal_green[it.idx] = it.ent_g;
                        pal_blue[it.idx] = it.ent_b;
                        pal_set[it.idx] = 1'b1;
                    end
                end
                CMD_LOAD_RED: begin
                    loads++;
                    red_tbl[it.idx] = it.pix;
                    red_set[it.idx] = 1'b1;
                end
                CMD_LOAD_GREEN: begin
                    loads++;
                    green_tbl[it.idx] = it.pix;
                    green_set[it.idx] = 1'b1;
                end
                CMD_LOAD_BLUE: begin
                    loads++;
                    blue_tbl[it.idx] = it.pix;
                    blue_set[it.idx] = 1'b1;
                end
                CMD_LOAD_CUBE: begin
                    loads++;
                    if (int'(it.idx) < CUBE_SIZE) begin
                        cube_tbl[it.idx] = it.pix;
                        cube_set[it.idx] = 1'b1;
                    end
                end
                CMD_CONVERT: begin
                    converted++;
                    converts_by_mode[int'(mode)]++;
                    pending_pixels.push_back(map_color(it));
                end
                default:
                    spares++;
            endcase
        endfunction

        function void check_result(input logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: pixel_value %h arrived with no conversion pending", got);
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: pixel_value expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] command;
    logic [CH_W-1:0] entry_index;
    logic [WIDE_W-1:0] entry_red;
    logic [WIDE_W-1:0] entry_green;
    logic [WIDE_W-1:0] entry_blue;
    logic [PIX_W-1:0] entry_pixel;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic done;
    logic [PIX_W-1:0] pixel_value;
    logic cfg_write;
    logic cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pixel_checker sb = new;
    int burst_left = 0;
    int idle_cycles = 0;

    mode_t phase_mode [PHASES] = '{MODE_DIRECT, MODE_NEAREST, MODE_CUBE, MODE_NEAREST,
                                   MODE_NEAREST, MODE_UNUSED, MODE_DIRECT, MODE_NEAREST,
                                   MODE_NEAREST, MODE_CUBE, MODE_NEAREST};
    logic [PE_W-1:0] phase_entries [PHASES] = '{9'd256, 9'd1, 9'd0, 9'd0, 9'd7, 9'd100,
                                               9'd3, 9'd256, 9'd511, 9'd300, 9'd0};

    rgb_to_pixel_mapper #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .entry_index(entry_index),
        .entry_red(entry_red),
        .entry_green(entry_green),
        .entry_blue(entry_blue),
        .entry_pixel(entry_pixel),
        .in_red(in_red),
        .in_green(in_green),
        .in_blue(in_blue),
        .done(done),
        .pixel_value(pixel_value),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(pixel_value);
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic map_item_t noise();
        map_item_t it;
        it.cmd = 3'($urandom_range(0, 7));
        it.idx = CH_W'($urandom);
        it.ent_r = WIDE_W'($urandom);
        it.ent_g = WIDE_W'($urandom);
        it.ent_b = WIDE_W'($urandom);
        it.pix = $urandom;
        it.r = CH_W'($urandom);
        it.g = CH_W'($urandom);
        it.b = CH_W'($urandom);
        return it;
    endfunction

    function automatic map_item_t load_item(input cmd_t c, input int idx,
                                            input logic [PIX_W-1:0] pix);
        map_item_t it;
        it = noise();
        it.cmd = c;
        it.idx = CH_W'(idx);
        it.pix = pix;
        return it;
    endfunction

    function automatic map_item_t palette_item(input int idx, input logic [WIDE_W-1:0] r,
                                               input logic [WIDE_W-1:0] g,
                                               input logic [WIDE_W-1:0] b);
        map_item_t it;
        it = noise();
        it.cmd = CMD_LOAD_PAL;
        it.idx = CH_W'(idx);
        it.ent_r = r;
        it.ent_g = g;
        it.ent_b = b;
        return it;
    endfunction

    function automatic map_item_t convert_item(input logic [CH_W-1:0] r,
                                               input logic [CH_W-1:0] g,
                                               input logic [CH_W-1:0] b);
        map_item_t it;
        it = noise();
        it.cmd = CMD_CONVERT;
        it.r = r;
        it.g = g;
        it.b = b;
        return it;
    endfunction

    // Palette channel: coarse values make exact matches and ties common
    function automatic logic [WIDE_W-1:0] pal_channel();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h8000;
            default: return WIDE_W'($urandom);
        endcase
    endfunction

    // Random written entry of a store, or -1 if none is written yet
    function automatic int pick_set(input bit [255:0] m, input int size);
        int s;
        s = $urandom_range(0, size - 1);
        for (int k = 0; k < size; k++) begin
            if (m[(s + k) % size]) return (s + k) % size;
        end
        return -1;
    endfunction

    // Next random item; a convert only reads entries that hold data
    function automatic map_item_t next_item();
        map_item_t it;
        int roll;
        int n;
        int hole;
        int ri;
        int gi;
        int bi;
        int ci;
        int qr;
        int qg;
        int qb;
        it = noise();
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            it.cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
            return it;
        end
        if (roll < 50) begin
            if ($urandom_range(0, 9) < 3 || sb.mode == MODE_UNUSED)
                it.cmd = 3'($urandom_range(int'(CMD_LOAD_PAL), int'(CMD_LOAD_CUBE)));
            else if (sb.mode == MODE_DIRECT)
                it.cmd = 3'($urandom_range(int'(CMD_LOAD_RED), int'(CMD_LOAD_BLUE)));
            else if (sb.mode == MODE_NEAREST)
                it.cmd = CMD_LOAD_PAL;
            else
                it.cmd = CMD_LOAD_CUBE;
            if (it.cmd == CMD_LOAD_PAL) begin
                it.ent_r = pal_channel();
                it.ent_g = pal_channel();
                it.ent_b = pal_channel();
            end
            return it;
        end
        case (sb.mode)
            MODE_DIRECT: begin
                ri = pick_set(256'(sb.red_set), CHANNEL_LEVELS);
                gi = pick_set(256'(sb.green_set), CHANNEL_LEVELS);
                bi = pick_set(256'(sb.blue_set), CHANNEL_LEVELS);
                if (ri < 0) return load_item(CMD_LOAD_RED, $urandom_range(0, 255), $urandom);
                if (gi < 0) return load_item(CMD_LOAD_GREEN, $urandom_range(0, 255), $urandom);
                if (bi < 0) return load_item(CMD_LOAD_BLUE, $urandom_range(0, 255), $urandom);
                return convert_item(CH_W'(ri), CH_W'(gi), CH_W'(bi));
            end
            MODE_NEAREST: begin
                n = sb.search_count();
                hole = -1;
                for (int p = n - 1; p >= 0; p--) begin
                    if (!sb.pal_set[p]) hole = p;
                end
                if (hole >= 0)
                    return palette_item(hole, pal_channel(), pal_channel(), pal_channel());
                if ($urandom_range(0, 1)) begin
                    ri = $urandom_range(0, n - 1);
                    return convert_item(sb.pal_red[ri][15:8], sb.pal_green[ri][15:8],
                                        sb.pal_blue[ri][15:8]);
                end
                return convert_item(it.r, it.g, it.b);
            end
            MODE_CUBE: begin
                ci = pick_set(sb.cube_set, CUBE_SIZE);
                if (ci < 0)
                    return load_item(CMD_LOAD_CUBE, $urandom_range(0, CUBE_SIZE - 1), $urandom);
                qr = ci / (CUBE_G_LEVELS * CUBE_B_LEVELS);
                qg = (ci / CUBE_B_LEVELS) % CUBE_G_LEVELS;
                qb = ci % CUBE_B_LEVELS;
                return convert_item(
                    CH_W'($urandom_range(qr * CUBE_RB_STEP,
                        (qr == CUBE_RB_MAXQ) ? 255 : qr * CUBE_RB_STEP + CUBE_RB_STEP - 1)),
                    CH_W'($urandom_range(qg * CUBE_G_STEP,
                        (qg == CUBE_G_MAXQ) ? 255 : qg * CUBE_G_STEP + CUBE_G_STEP - 1)),
                    CH_W'($urandom_range(qb * CUBE_RB_STEP,
                        (qb == CUBE_RB_MAXQ) ? 255 : qb * CUBE_RB_STEP + CUBE_RB_STEP - 1)));
            end
            default:
                return convert_item(it.r, it.g, it.b);
        endcase
    endfunction

    // Drive one item after a random gap and hold it until the block takes it
    task automatic send_item(input map_item_t it);
        int gap;
        bit took;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 30);
            gap = 0;
        end
        else
            gap = $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        command <= it.cmd;
        entry_index <= it.idx;
        entry_red <= it.ent_r;
        entry_green <= it.ent_g;
        entry_blue <= it.ent_b;
        entry_pixel <= it.pix;
        in_red <= it.r;
        in_green <= it.g;
        in_blue <= it.b;
        took = 1'b0;
        while (!took) begin
            @(posedge clk);
            took = !busy;
            if (took) sb.note_item(it);
            @(negedge clk);
        end
    endtask

    // Drop start and wait until every owed pixel is in and the block is quiet
    task automatic settle();
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0 || busy) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers; the mode word carries random upper bits
    task automatic configure(input mode_t m, input logic [PE_W-1:0] pe);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = {7'($urandom), m};
        cfg_write <= 1'b1;
        cfg_index <= REG_MAP_MODE;
        cfg_data <= mode_word;
        @(posedge clk);
        sb.write_reg(REG_MAP_MODE, mode_word);
        @(negedge clk);
        cfg_index <= REG_PALETTE_ENTRIES;
        cfg_data <= pe;
        @(posedge clk);
        sb.write_reg(REG_PALETTE_ENTRIES, pe);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int goal;
        logic [PE_W-1:0] pe;
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        entry_index = '0;
        entry_red = '0;
        entry_green = '0;
        entry_blue = '0;
        entry_pixel = '0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        cfg_write = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Direct mode at the table extremes, plus the spare commands
        send_item(load_item(CMD_LOAD_RED, 0, 32'h0000_0000));
        send_item(load_item(CMD_LOAD_GREEN, 0, 32'h0000_0000));
        send_item(load_item(CMD_LOAD_BLUE, 0, 32'h0000_0000));
        send_item(convert_item(8'h00, 8'h00, 8'h00));
        send_item(load_item(CMD_LOAD_RED, 255, 32'hFFFF_FFFF));
        send_item(load_item(CMD_LOAD_GREEN, 255, 32'h0000_FF00));
        send_item(load_item(CMD_LOAD_BLUE, 255, 32'h8000_0001));
        send_item(convert_item(8'hFF, 8'hFF, 8'hFF));
        send_item(convert_item(8'h00, 8'hFF, 8'hFF));
        send_item(load_item(cmd_t'(CMD_SPARE_LO), 0, $urandom));
        send_item(load_item(cmd_t'(CMD_SPARE_HI), 255, $urandom));

        // Cube corners; loads past the last cube entry must be dropped
        send_item(load_item(CMD_LOAD_CUBE, 0, 32'hA5A5_A5A5));
        send_item(load_item(CMD_LOAD_CUBE, CUBE_SIZE - 1, 32'h5A5A_5A5A));
        send_item(load_item(CMD_LOAD_CUBE, CUBE_SIZE, 32'hFFFF_FFFF));
        send_item(load_item(CMD_LOAD_CUBE, 255, 32'hFFFF_FFFF));
        settle();
        configure(MODE_CUBE, PALETTE_ENTRIES_RESET);
        send_item(convert_item(8'd51, 8'd30, 8'd51));
        send_item(convert_item(8'hFF, 8'hFF, 8'hFF));

        // Unused mode answers zero
        settle();
        configure(MODE_UNUSED, PALETTE_ENTRIES_RESET);
        send_item(convert_item(8'hFF, 8'h00, 8'hFF));

        // Nearest search with one entry, with a zero count, and a tie
        settle();
        configure(MODE_NEAREST, 9'd1);
        send_item(palette_item(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(convert_item(8'h00, 8'h00, 8'h00));
        settle();
        configure(MODE_NEAREST, 9'd0);
        send_item(convert_item(8'hFF, 8'hFF, 8'hFF));
        settle();
        configure(MODE_NEAREST, 9'd3);
        send_item(palette_item(1, 16'h0000, 16'h0000, 16'h0000));
        send_item(palette_item(2, 16'h0000, 16'h0000, 16'h0000));
        send_item(convert_item(8'h00, 8'h00, 8'h00));

        // Random phases over a spread of register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            pe = phase_entries[ph];
            if (ph == PHASES - 1) pe = PE_W'($urandom_range(2, 40));
            settle();
            configure(phase_mode[ph], pe);
            goal = sb.converted + CONVERTS_PER_PHASE;
            while (sb.converted < goal) send_item(next_item());
        end

        // Drain and look for stray results
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Summary: %0d loads, %0d spare commands, %0d conversions, %0d results checked",
                 sb.loads, sb.spares, sb.converted, sb.checked);
        $display("Conversions by mode: direct %0d, nearest %0d, cube %0d, unused %0d; %0d errors",
                 sb.converts_by_mode[0], sb.converts_by_mode[1], sb.converts_by_mode[2],
                 sb.converts_by_mode[3], sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rgbpm_pkg.sv
sv/rgb_to_pixel_mapper.sv
sim/tb_top.sv
